/* design/brf_pkg.sv */
// Shared constants for the byte ring FIFO: store depth, widths and request mode codes.
package brf_pkg;

   localparam int DEPTH  = 1024;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int SIZE_W = PTR_W + 1;

   localparam logic [2:0] MODE_PUSH      = 3'd0;
   localparam logic [2:0] MODE_POP       = 3'd1;
   localparam logic [2:0] MODE_PEEK      = 3'd2;
   localparam logic [2:0] MODE_TAIL_FWD  = 3'd3;
   localparam logic [2:0] MODE_TAIL_BACK = 3'd4;

   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(DEPTH);

endpackage

/* design/byte_ring_fifo_unit.sv */
// Byte ring FIFO top level: request decode, pointer update, byte store and response register.
//
// Byte ring FIFO over a 1024 x 8 synchronous store, wrapping at a settable size in use
// (2..1024, clamped) and keeping one slot empty, so it holds at most size - 1 bytes. Each
// request pushes, pops, peeks at a raw slot, or moves the read position forward or back
// with wrap (committed or only reported). Every response carries the occupancy after the
// request and the read position the request computed; tlast echoes the request's tlast.
// After reset the store is swept to zero, one slot a cycle, over 1024 slots; no request is
// taken then, but the size register may be written. Push, tail and unused-mode requests answer
// in the cycle after acceptance and can be taken every cycle while the response register is
// free. Pop and peek read the store through its registered port, then hold the block in the
// lookup state until the response register is free. A new request is taken while a response
// waits, as long as the response register is free or being drained in the same cycle. Writing
// the size register empties the ring (both positions go to zero); the bytes stay in the store.
module byte_ring_fifo_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // mode[2:0], write_byte[10:3], position[20:11],
                                   // step[28:21], move_read_pointer[29], zero[31:30]
   input  logic        req_tlast,  // burst_end
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // read_byte[7:0], done_res[8], occupancy[18:9],
                                   // tail_result[28:19], zero[31:29]
   output logic        rsp_tlast,  // burst_end_echo
   // size register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data    // size_in_use
);

   localparam int PW = brf_pkg::PTR_W;
   localparam int SW = brf_pkg::SIZE_W;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // request fields
   logic [2:0]    req_mode;
   logic [7:0]    req_wbyte;
   logic [PW-1:0] req_pos;
   logic [7:0]    req_step;
   logic          req_commit;

   assign req_mode   = req_tdata[2:0];
   assign req_wbyte  = req_tdata[10:3];
   assign req_pos    = req_tdata[20:11];
   assign req_step   = req_tdata[28:21];
   assign req_commit = req_tdata[29];

   // state
   state_type     state_ff;
   logic [PW-1:0] clr_addr_ff;
   logic [PW-1:0] wp_ff;
   logic [PW-1:0] rp_ff;
   logic [SW-1:0] size_ff;

   // response register
   logic          rsp_valid_ff;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_done_ff;
   logic [PW-1:0] rsp_occ_ff;
   logic [PW-1:0] rsp_tail_ff;
   logic          rsp_last_ff;

   // fields parked while the store read is in flight
   logic          pend_done_ff;
   logic [PW-1:0] pend_occ_ff;
   logic [PW-1:0] pend_tail_ff;
   logic          pend_last_ff;

   // store
   logic [7:0]    store_mem [brf_pkg::DEPTH];
   logic [7:0]    mem_q_ff;

   logic          rsp_free;
   logic          accept;
   logic          csr_write;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid;

   // wrap helpers
   logic [SW-1:0] wp_inc;
   logic [SW-1:0] rp_inc;
   logic [PW-1:0] wp_next_slot;
   logic [PW-1:0] rp_next_slot;

   assign wp_inc       = {1'b0, wp_ff} + SW'(1);
   assign rp_inc       = {1'b0, rp_ff} + SW'(1);
   assign wp_next_slot = (wp_inc >= size_ff) ? '0 : wp_inc[PW-1:0];
   assign rp_next_slot = (rp_inc >= size_ff) ? '0 : rp_inc[PW-1:0];

   // tail move
   logic [SW-1:0] fwd_sum;
   logic [SW-1:0] tail_fwd;
   logic [SW-1:0] tail_back;
   logic          step_ok;

   assign fwd_sum  = {1'b0, rp_ff} + SW'(req_step);
   assign tail_fwd = (fwd_sum >= size_ff) ? fwd_sum - size_ff : fwd_sum;
   assign tail_back = ({1'b0, rp_ff} >= SW'(req_step)) ?
                      {1'b0, rp_ff} - SW'(req_step) :
                      size_ff - SW'(req_step) + {1'b0, rp_ff};
   assign step_ok  = SW'(req_step) < size_ff;

   // request decode
   logic [PW-1:0] wp_in;
   logic [PW-1:0] rp_in;
   logic          done_in;
   logic [PW-1:0] tail_in;
   logic          rd_need;
   logic          push_wr;
   logic [PW-1:0] rd_addr;

   always_comb begin
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      done_in = 1'b0;
      tail_in = rp_ff;
      rd_need = 1'b0;
      push_wr = 1'b0;
      rd_addr = rp_ff;
      unique case (req_mode)
         brf_pkg::MODE_PUSH: begin
            if (wp_next_slot != rp_ff) begin
               push_wr = 1'b1;
               wp_in   = wp_next_slot;
               done_in = 1'b1;
            end
         end
         brf_pkg::MODE_POP: begin
            rd_need = 1'b1;
            if (rp_ff != wp_ff) begin
               rp_in   = rp_next_slot;
               tail_in = rp_next_slot;
               done_in = 1'b1;
            end
         end
         brf_pkg::MODE_PEEK: begin
            // every 10-bit position lies inside the store
            rd_need = 1'b1;
            rd_addr = req_pos;
            done_in = 1'b1;
         end
         brf_pkg::MODE_TAIL_FWD, brf_pkg::MODE_TAIL_BACK: begin
            if (step_ok) begin
               tail_in = (req_mode == brf_pkg::MODE_TAIL_FWD) ? tail_fwd[PW-1:0]
                                                              : tail_back[PW-1:0];
               done_in = 1'b1;
               if (req_commit) begin
                  rp_in = tail_in;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // occupancy after the request
   logic [SW-1:0] held_full;
   logic [PW-1:0] occ_in;

   assign held_full = (wp_in >= rp_in) ? {1'b0, wp_in} - {1'b0, rp_in}
                                       : size_ff - {1'b0, rp_in} + {1'b0, wp_in};
   assign occ_in    = held_full[PW-1:0];

   // size clamp
   logic [SW-1:0] size_in;

   always_comb begin
      priority if (csr_data < brf_pkg::SIZE_MIN) begin
         size_in = brf_pkg::SIZE_MIN;
      end else if (csr_data > SW'(brf_pkg::DEPTH)) begin
         size_in = SW'(brf_pkg::DEPTH);
      end else begin
         size_in = csr_data;
      end
   end

   // store port: clearing sweep or push writes, pop and peek read
   logic          mem_we;
   logic [PW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic          mem_re;

   assign mem_we    = (state_ff == ST_CLEAR) || (accept && push_wr);
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : wp_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? 8'd0 : req_wbyte;
   assign mem_re    = accept && rd_need;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= store_mem[rd_addr];
      end
   end

   // response register loads on a direct answer or when the store byte is back
   logic          rsp_load;

   assign rsp_load = (accept && !rd_need) || ((state_ff == ST_LOOKUP) && rsp_free);

   // control and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         size_ff      <= brf_pkg::SIZE_RESET;
         rsp_valid_ff <= 1'b0;
         rsp_byte_ff  <= '0;
         rsp_done_ff  <= 1'b0;
         rsp_occ_ff   <= '0;
         rsp_tail_ff  <= '0;
         rsp_last_ff  <= 1'b0;
         pend_done_ff <= 1'b0;
         pend_occ_ff  <= '0;
         pend_tail_ff <= '0;
         pend_last_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_tready);
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + PW'(1);
               if (clr_addr_ff == PW'(brf_pkg::DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  if (rd_need) begin
                     // byte arrives from the store next cycle
                     pend_done_ff <= done_in;
                     pend_occ_ff  <= occ_in;
                     pend_tail_ff <= tail_in;
                     pend_last_ff <= req_tlast;
                     state_ff     <= ST_LOOKUP;
                  end else begin
                     rsp_byte_ff  <= '0;
                     rsp_done_ff  <= done_in;
                     rsp_occ_ff   <= occ_in;
                     rsp_tail_ff  <= tail_in;
                     rsp_last_ff  <= req_tlast;
                  end
               end
            end
            ST_LOOKUP: begin
               if (rsp_free) begin
                  // an empty pop reports a zero byte
                  rsp_byte_ff  <= pend_done_ff ? mem_q_ff : 8'd0;
                  rsp_done_ff  <= pend_done_ff;
                  rsp_occ_ff   <= pend_occ_ff;
                  rsp_tail_ff  <= pend_tail_ff;
                  rsp_last_ff  <= pend_last_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
         // size write empties the ring; the store keeps its bytes
         if (csr_write) begin
            size_ff <= size_in;
            wp_ff   <= '0;
            rp_ff   <= '0;
         end else if (accept) begin
            wp_ff <= wp_in;
            rp_ff <= rp_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_tail_ff, rsp_occ_ff, rsp_done_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
